// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define CPD_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cpd assertion failed");

// clocked assertion that is also checked during reset
`define CPD_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cpd reset assertion failed");

`endif

// ===== hw/rtl/cpd_pkg.sv =====
`timescale 1ns / 1ps
package cpd_pkg;

  localparam logic [7:0] UNCHECKED_MARK = 8'h88;
  localparam logic [7:0] SUM_BASE       = 8'hAA;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UNCHECKED,
    ST_MISMATCH,
    ST_ZERO_LEN
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] category;
    logic [2:0] command;
    status_t    status;
    logic [7:0] expected_sum;
    logic [7:0] received_sum;
    logic       last;
  } out_item_t;

  // parser result toward the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } parse_res_t;

endpackage

// ===== hw/rtl/cpd_channel_if.sv =====
`timescale 1ns / 1ps
interface cpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_start;

  modport source (output valid, output in_byte, output frame_start, input ready);
  modport sink (input valid, input in_byte, input frame_start, output ready);
endinterface

interface cpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [3:0] category;
  logic [2:0] command;
  logic [1:0] status;
  logic [7:0] expected_sum;
  logic [7:0] received_sum;
  logic       last;

  modport source (
    output valid, output data_byte, output category, output command, output status,
    output expected_sum, output received_sum, output last, input ready
  );
  modport sink (
    input valid, input data_byte, input category, input command, input status,
    input expected_sum, input received_sum, input last, output ready
  );
endinterface

// ===== hw/rtl/command_packet_deframer_core.sv =====
`timescale 1ns / 1ps
// command packet deframer core
// in_if: one message byte per item plus frame_start, which marks a command byte.
//   a message is command byte, length low, length high, payload, checksum byte.
// out_if: one item per payload byte (last = 0) and one end item (last = 1) that
//   carries the status, the expected sum (0xAA minus the byte sum) and the
//   received checksum byte. header bytes produce no item, but for a zero length
//   the length high byte produces the end item, with no checksum byte.
// the parser steps as a byte leaves the input register into the result register.
// throughput: one byte per cycle unless out_if holds back a pending result
//   (one 8-bit add, one 16-bit decrement and compare per parser step).
// reset: synchronous rst_n empties both registers and returns the parser to
//   waiting for a command byte.
// stall: while out_if is held and a result is pending, the input register
//   still takes one byte; bytes that produce no result keep flowing through.
module command_packet_deframer_core import cpd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  cpd_in_if.sink          in_if,
  cpd_out_if.source       out_if
);

  in_item_t   in_item;
  in_item_t   item;
  logic       item_valid;
  logic       advance;
  parse_res_t res;
  logic       out_valid;
  out_item_t  out_item;

  assign in_item.in_byte     = in_if.in_byte;
  assign in_item.frame_start = in_if.frame_start;

  // the held byte moves on unless it makes a result that cannot be stored
  assign advance = !item_valid || !res.valid || !out_valid || out_if.ready;

  cpd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cpd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (item_valid && advance),
    .item  (item),
    .res   (res)
  );

  cpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (item_valid && advance),
    .res       (res),
    .out_ready (out_if.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_if.valid        = out_valid;
  assign out_if.data_byte    = out_item.data_byte;
  assign out_if.category     = out_item.category;
  assign out_if.command      = out_item.command;
  assign out_if.status       = out_item.status;
  assign out_if.expected_sum = out_item.expected_sum;
  assign out_if.received_sum = out_item.received_sum;
  assign out_if.last         = out_item.last;

endmodule

// ===== hw/rtl/cpd_in_reg.sv =====
`timescale 1ns / 1ps
module cpd_in_reg import cpd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== hw/rtl/cpd_parser.sv =====
`timescale 1ns / 1ps
module cpd_parser import cpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_item_t   item,
  output parse_res_t res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [3:0]  cat_r, cat_nxt;
  logic [2:0]  cmd_r, cmd_nxt;

  logic [7:0]  b;
  logic [7:0]  sum_plus;
  logic [7:0]  exp_cur;
  logic [15:0] len_full;

  assign b        = item.in_byte;
  assign sum_plus = sum_r + b;
  assign exp_cur  = SUM_BASE - sum_r;
  assign len_full = {b, len_lo_r};

  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    sum_nxt    = sum_r;
    len_lo_nxt = len_lo_r;
    cat_nxt    = cat_r;
    cmd_nxt    = cmd_r;

    res.valid             = 1'b0;
    res.item.data_byte    = '0;
    res.item.category     = cat_r;
    res.item.command      = cmd_r;
    res.item.status       = ST_OK;
    res.item.expected_sum = '0;
    res.item.received_sum = '0;
    res.item.last         = 1'b0;

    if (item.frame_start || phase_r == PH_WAIT) begin
      cat_nxt   = b[7:4];
      cmd_nxt   = b[3:1];
      sum_nxt   = b;
      left_nxt  = '0;
      phase_nxt = PH_LEN_LO;
    end else begin
      case (phase_r)
        PH_LEN_LO: begin
          len_lo_nxt = b;
          sum_nxt    = sum_plus;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          sum_nxt  = sum_plus;
          left_nxt = len_full;
          if (len_full == '0) begin
            res.valid             = 1'b1;
            res.item.status       = ST_ZERO_LEN;
            res.item.expected_sum = SUM_BASE - sum_plus;
            res.item.last         = 1'b1;
            phase_nxt             = PH_WAIT;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          res.valid = 1'b1;
          if (left_r <= 16'd1) begin
            // checksum byte closes the message
            res.item.expected_sum = exp_cur;
            res.item.received_sum = b;
            res.item.last         = 1'b1;
            if (b == UNCHECKED_MARK) begin
              res.item.status = ST_UNCHECKED;
            end else if (b == exp_cur) begin
              res.item.status = ST_OK;
            end else begin
              res.item.status = ST_MISMATCH;
            end
            left_nxt  = '0;
            phase_nxt = PH_WAIT;
          end else begin
            res.item.data_byte = b;
            sum_nxt            = sum_plus;
            left_nxt           = left_r - 16'd1;
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      left_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sum_r    <= sum_nxt;
      len_lo_r <= len_lo_nxt;
      cat_r    <= cat_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

endmodule

// ===== hw/rtl/cpd_out_reg.sv =====
`timescale 1ns / 1ps
module cpd_out_reg import cpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  parse_res_t res,
  input  logic       out_ready,
  output logic       out_valid,
  output out_item_t  out_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign out_valid = valid_r;
  assign out_item  = item_r;

  // a step without a result leaves a pending item in place
  always_comb begin
    if (load && res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      item_r <= res.item;
    end
  end

endmodule

// ===== hw/rtl/cpd_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cpd_checker import cpd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic [1:0] status,
  input logic [7:0] expected_sum,
  input logic [7:0] received_sum,
  input logic       last
);

  `CPD_ASSERT_RST(a_reset_empties_out, clk, !rst_n |=> !out_valid)

  // payload items carry no checksum information
  `CPD_ASSERT(a_payload_clean, clk, rst_n, (out_valid && !last) |-> (status == ST_OK && expected_sum == 8'h00 && received_sum == 8'h00))

  // end items agree with their own comparison
  `CPD_ASSERT(a_end_consistent, clk, rst_n, (out_valid && last) |-> (data_byte == 8'h00 && (status != ST_OK || received_sum == expected_sum) && (status != ST_MISMATCH || received_sum != expected_sum) && (status != ST_UNCHECKED || received_sum == UNCHECKED_MARK) && (status != ST_ZERO_LEN || received_sum == 8'h00)))

  `CPD_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(data_byte) && $stable(last)))

endmodule

bind command_packet_deframer_core cpd_checker u_cpd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .data_byte    (out_if.data_byte),
  .status       (out_if.status),
  .expected_sum (out_if.expected_sum),
  .received_sum (out_if.received_sum),
  .last         (out_if.last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import cpd_pkg::*;

  typedef enum int {CHK_GOOD, CHK_MARK, CHK_BAD, CHK_RANDOM} chk_kind_t;

  localparam int unsigned ALL_BYTES   = 32'hFFFF_FFFF;
  localparam int unsigned TARGET_ITEMS = 1600;

  // tracks the parser state and the results each accepted byte must produce
  class deframe_checker;
    phase_t      ph;
    logic [15:0] remaining;
    logic [7:0]  byte_sum;
    logic [7:0]  len_lo;
    logic [3:0]  cat;
    logic [2:0]  cmd;
    out_item_t   expected_items[$];
    int          errors;

    function new();
      ph        = PH_WAIT;
      remaining = '0;
      byte_sum  = '0;
      len_lo    = '0;
      cat       = '0;
      cmd       = '0;
      errors    = 0;
    endfunction

    task report(string msg);
      $display("tb: mismatch, %s", msg);
      errors++;
    endtask

    function void note_byte(logic [7:0] b, logic fs);
      out_item_t e;
      e = '0;
      e.category = cat;
      e.command  = cmd;
      // a marked byte, or any byte while waiting, opens a new message
      if (fs || ph == PH_WAIT) begin
        cat       = b[7:4];
        cmd       = b[3:1];
        byte_sum  = b;
        remaining = '0;
        ph        = PH_LEN_LO;
      end else begin
        case (ph)
          PH_LEN_LO: begin
            len_lo   = b;
            byte_sum = byte_sum + b;
            ph       = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            byte_sum  = byte_sum + b;
            remaining = {b, len_lo};
            if (remaining == 16'd0) begin
              e.status       = ST_ZERO_LEN;
              e.expected_sum = SUM_BASE - byte_sum;
              e.last         = 1'b1;
              expected_items.push_back(e);
              ph = PH_WAIT;
            end else begin
              ph = PH_BODY;
            end
          end
          default: begin
            if (remaining <= 16'd1) begin
              e.expected_sum = SUM_BASE - byte_sum;
              e.received_sum = b;
              e.last         = 1'b1;
              if (b == UNCHECKED_MARK) begin
                e.status = ST_UNCHECKED;
              end else if (b == e.expected_sum) begin
                e.status = ST_OK;
              end else begin
                e.status = ST_MISMATCH;
              end
              expected_items.push_back(e);
              remaining = '0;
              ph        = PH_WAIT;
            end else begin
              byte_sum  = byte_sum + b;
              remaining = remaining - 16'd1;
              e.data_byte = b;
              expected_items.push_back(e);
            end
          end
        endcase
      end
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0h want %0h", name, got, want));
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_items.size() == 0) begin
        report("result with nothing pending");
      end else begin
        want = expected_items.pop_front();
        check_field("data_byte", got.data_byte, want.data_byte);
        check_field("category", 8'(got.category), 8'(want.category));
        check_field("command", 8'(got.command), 8'(want.command));
        check_field("status", 8'(got.status), 8'(want.status));
        check_field("expected_sum", got.expected_sum, want.expected_sum);
        check_field("received_sum", got.received_sum, want.received_sum);
        check_field("last", 8'(got.last), 8'(want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  cpd_in_if  in_ch ();
  cpd_out_if out_ch ();

  command_packet_deframer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  deframe_checker chk = new();

  int unsigned items_sent;
  int unsigned burst_left;
  bit          need_start;

  int unsigned rx_cnt;
  int unsigned rx_mode;
  int unsigned rx_hold;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // sample both channels at the rising edge
  always @(posedge clk) begin
    out_item_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        chk.note_byte(in_ch.in_byte, in_ch.frame_start);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.data_byte    = out_ch.data_byte;
        got.category     = out_ch.category;
        got.command      = out_ch.command;
        got.status       = status_t'(out_ch.status);
        got.expected_sum = out_ch.expected_sum;
        got.received_sum = out_ch.received_sum;
        got.last         = out_ch.last;
        chk.check_result(got);
      end
    end
  end

  // receiver stall pattern in four styles, switching between them at random
  initial begin
    out_ch.ready = 1'b0;
    rx_cnt  = 0;
    rx_mode = 0;
    rx_hold = 0;
  end

  always @(negedge clk) begin
    rx_cnt++;
    if (rx_cnt % 128 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    case (rx_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 3) != 0);
      2: out_ch.ready = ((rx_cnt % 5) < 2);
      default: begin
        if (rx_hold > 0) begin
          out_ch.ready = 1'b0;
          rx_hold--;
        end else begin
          out_ch.ready = 1'b1;
          if ($urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(4, 16);
          end
        end
      end
    endcase
  end

  // sender works in bursts with random gaps between them
  task automatic send_byte(logic [7:0] b, logic fs);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = 8'($urandom);
        in_ch.frame_start = 1'($urandom_range(0, 1));
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.in_byte     = b;
    in_ch.frame_start = fs;
    burst_left--;
    items_sent++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // pay < 0 gives random payload; cut stops the message early
  task automatic send_frame(bit fs_first, logic [7:0] cmd, int unsigned len, int pay,
                            chk_kind_t kind, int unsigned cut);
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [15:0] len16;
    int unsigned total;
    int unsigned count;
    len16 = len[15:0];
    total = 3 + len;
    count = (cut < total) ? cut : total;
    sum   = '0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == 0) begin
        b = cmd;
      end else if (i == 1) begin
        b = len16[7:0];
      end else if (i == 2) begin
        b = len16[15:8];
      end else if (i < total - 1) begin
        b = (pay < 0) ? 8'($urandom) : pay[7:0];
      end else begin
        case (kind)
          CHK_GOOD: b = SUM_BASE - sum;
          CHK_MARK: b = UNCHECKED_MARK;
          CHK_BAD:  b = (SUM_BASE - sum) ^ 8'($urandom_range(1, 255));
          default:  b = 8'($urandom);
        endcase
      end
      if (i < total - 1) begin
        sum = sum + b;
      end
      send_byte(b, (i == 0) ? fs_first : 1'b0);
    end
    need_start = (count < total);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (chk.expected_items.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned c;
    chk_kind_t   kind;
    bit          pressure_done;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = '0;
    in_ch.frame_start = 1'b0;
    items_sent    = 0;
    burst_left    = 0;
    need_start    = 1'b0;
    pressure_done = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every status, zero length, length one, abort
    send_frame(1'b1, 8'hFF, 1, -1, CHK_GOOD, ALL_BYTES);
    send_frame(1'b0, 8'h00, 0, -1, CHK_GOOD, ALL_BYTES);
    send_frame(1'b1, 8'h5A, 3, 8'hFF, CHK_MARK, ALL_BYTES);
    send_frame(1'b0, 8'hA5, 2, 8'h00, CHK_BAD, ALL_BYTES);
    send_frame(1'b1, 8'h3C, 16'hFFFF, -1, CHK_GOOD, 5);
    send_frame(1'b1, 8'hC3, 1, -1, CHK_BAD, ALL_BYTES);

    while (items_sent < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        len = 0;
      end else if (r < 50) begin
        len = $urandom_range(1, 4);
      end else if (r < 85) begin
        len = $urandom_range(5, 20);
      end else if (r < 98) begin
        len = $urandom_range(21, 80);
      end else begin
        len = $urandom_range(200, 400);
      end
      c = $urandom_range(0, 9);
      kind = (c < 6) ? CHK_GOOD : (c < 8) ? CHK_MARK : (c < 9) ? CHK_BAD : CHK_RANDOM;
      r = $urandom_range(0, 19);
      if (r < 16) begin
        send_frame(need_start ? 1'b1 : 1'($urandom_range(0, 1)), 8'($urandom), len, -1,
                   kind, ALL_BYTES);
      end else if (r < 18) begin
        // message cut short, the next one is marked with frame_start
        send_frame(need_start ? 1'b1 : 1'($urandom_range(0, 1)), 8'($urandom), len, -1,
                   kind, $urandom_range(1, len + 2));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        need_start = 1'b1;
      end
      if (!pressure_done && items_sent >= TARGET_ITEMS / 2) begin
        drain();
        pressure_done = 1'b1;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (chk.errors == 0 && chk.expected_items.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== command_packet_deframer_core.f =====
+incdir+hw/rtl
hw/rtl/cpd_pkg.sv
hw/rtl/cpd_channel_if.sv
hw/rtl/cpd_in_reg.sv
hw/rtl/cpd_parser.sv
hw/rtl/cpd_out_reg.sv
hw/rtl/command_packet_deframer_core.sv
hw/rtl/cpd_checker.sv
tb/tb_top.sv
